// File: rtl/svd_pkg.sv
package svd_pkg;

  localparam int unsigned SAMPLE_W   = 24;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned DELAY_W    = 24;
  localparam int unsigned LFO_W      = 17;
  localparam int unsigned FIFO_DEPTH = 2;

  localparam int unsigned DELAY_DEPTH_DEF  = 2048;
  localparam int unsigned SINE_ENTRIES_DEF = 256;

  localparam longint Q30         = 64'sd1073741824;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  // Denominators (2n)(2n+1) of the odd sine series terms up to x^13.
  localparam longint TaylorDiv [6] = '{6, 20, 42, 72, 110, 156};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_STEP = 3'd0,
    CFG_HALF_DELAY = 3'd1,
    CFG_DEPTH      = 3'd2,
    CFG_WAVE       = 3'd3,
    CFG_MIX        = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    WAVE_SINE   = 2'd0,
    WAVE_TRI    = 2'd1,
    WAVE_SQUARE = 2'd2,
    WAVE_SAW    = 2'd3
  } wave_e;

  typedef struct packed {
    logic [31:0] phase_step;
    logic [18:0] half_delay;
    logic [16:0] depth;
    wave_e       wave;
    logic [16:0] mix;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
    logic [DELAY_W-1:0]         delay;
  } job_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_IDX,
    F_LFO,
    F_MUL1,
    F_MUL2,
    F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_WRITE,
    B_RD0,
    B_RD1,
    B_INTERP,
    B_MIX1,
    B_MIX2
  } back_state_e;

endpackage

// File: rtl/svd_if.sv
interface svd_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [svd_pkg::SAMPLE_W-1:0] left_in;
  logic signed [svd_pkg::SAMPLE_W-1:0] right_in;

  modport source (output valid, output left_in, output right_in, input ready);
  modport sink (input valid, input left_in, input right_in, output ready);
endinterface

interface svd_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [svd_pkg::SAMPLE_W-1:0] left_out;
  logic signed [svd_pkg::SAMPLE_W-1:0] right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink (input valid, input left_out, input right_out, output ready);
endinterface

interface svd_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [svd_pkg::CFG_IDX_W-1:0]        index;
  logic [svd_pkg::CFG_DATA_W-1:0]       data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/svd_ram.sv
module svd_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/svd_front.sv
module svd_front #(
  parameter int unsigned DelayDepth  = svd_pkg::DELAY_DEPTH_DEF,
  parameter int unsigned SineEntries = svd_pkg::SINE_ENTRIES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  svd_pkg::cfg_t cfg_i,
  svd_in_if.sink        in_i,
  output logic          push_valid_o,
  output svd_pkg::job_t push_job_o,
  input  logic          push_ready_i
);

  localparam int unsigned PW = $clog2(4 * SineEntries);
  localparam int unsigned IW = $clog2(SineEntries + 1);
  localparam longint unsigned Span = 4 * SineEntries;
  localparam longint MaxDelay = (longint'(DelayDepth) - 1) * 256;

  // Quarter-wave table entry k, built from the sine series in Q30.
  function automatic logic [16:0] sine_entry(input int k);
    longint x;
    longint term;
    longint sum;
    longint val;
    x = longint'(k) * svd_pkg::HALF_PI_Q30 / SineEntries;
    term = x;
    sum = x;
    for (int n = 0; n < 6; n++) begin
      term = term * x / svd_pkg::Q30;
      term = term * x / svd_pkg::Q30;
      term = -term / svd_pkg::TaylorDiv[n];
      sum = sum + term;
    end
    if (sum < 0) begin
      sum = 0;
    end
    val = (sum * 32768 + svd_pkg::Q30 / 2) / svd_pkg::Q30;
    if (val > 32768) begin
      val = 32768;
    end
    return 17'(val);
  endfunction

  logic [16:0] rom [SineEntries + 1];

  for (genvar k = 0; k <= SineEntries; k++) begin : g_rom
    localparam logic [16:0] Entry = sine_entry(k);
    assign rom[k] = Entry;
  end

  svd_pkg::front_state_e state_q, state_d;
  logic [31:0]                  phase_q;
  logic signed [svd_pkg::SAMPLE_W-1:0] left_q, right_q;
  logic [PW-1:0]                p_q, p_d;
  logic signed [svd_pkg::LFO_W-1:0] lfo_q, lfo_d;
  logic [32:0]                  sum_q, sum_d;
  logic [51:0]                  prod_q, prod_d;
  logic [svd_pkg::DELAY_W-1:0]  delay_d;
  logic                         accept;

  assign accept = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= svd_pkg::F_IDLE;
      phase_q <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        phase_q <= phase_q + cfg_i.phase_step;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      left_q  <= in_i.left_in;
      right_q <= in_i.right_in;
    end
    if (state_q == svd_pkg::F_IDX) begin
      p_q <= p_d;
    end
    if (state_q == svd_pkg::F_LFO) begin
      lfo_q <= lfo_d;
    end
    if (state_q == svd_pkg::F_MUL1) begin
      sum_q <= sum_d;
    end
    if (state_q == svd_pkg::F_MUL2) begin
      prod_q <= prod_d;
    end
  end

  // Table position: the phase scaled to four quarter waves.
  always_comb begin
    logic [63:0] pmul;
    pmul = {32'b0, phase_q} * 64'(Span);
    p_d = pmul[32+PW-1:32];
  end

  always_comb begin
    logic [PW:0]         pe;
    logic [PW:0]         off;
    logic [1:0]          quad;
    logic [IW-1:0]       ridx;
    logic [16:0]         mag;
    logic signed [18:0]  tri_v;
    logic signed [18:0]  saw_v;
    logic signed [16:0]  sine_v;
    pe = {1'b0, p_q};
    priority if (pe < (PW+1)'(SineEntries)) begin
      quad = 2'd0;
      off  = pe;
    end else if (pe < (PW+1)'(2 * SineEntries)) begin
      quad = 2'd1;
      off  = pe - (PW+1)'(SineEntries);
    end else if (pe < (PW+1)'(3 * SineEntries)) begin
      quad = 2'd2;
      off  = pe - (PW+1)'(2 * SineEntries);
    end else begin
      quad = 2'd3;
      off  = pe - (PW+1)'(3 * SineEntries);
    end
    ridx   = quad[0] ? IW'(SineEntries - 32'(off)) : IW'(off);
    mag    = rom[ridx];
    sine_v = quad[1] ? -$signed(mag) : $signed(mag);
    if (!phase_q[31]) begin
      tri_v = $signed({2'b0, phase_q[31:15]}) - 19'sd32768;
    end else begin
      tri_v = 19'sd98304 - $signed({2'b0, phase_q[31:15]});
    end
    saw_v = $signed({3'b0, phase_q[31:16]}) - 19'sd32768;
    unique case (cfg_i.wave)
      svd_pkg::WAVE_SINE:   lfo_d = sine_v;
      svd_pkg::WAVE_TRI:    lfo_d = 17'(tri_v);
      svd_pkg::WAVE_SQUARE: lfo_d = phase_q[31] ? -17'sd32768 : 17'sd32768;
      svd_pkg::WAVE_SAW:    lfo_d = 17'(saw_v);
      default:              lfo_d = '0;
    endcase
  end

  // The modulation term never drops below -2^31, so the sum is non-negative.
  always_comb begin
    logic [16:0]        dsat;
    logic signed [34:0] modv;
    logic signed [35:0] sum_s;
    dsat  = (cfg_i.depth > 17'd65536) ? 17'd65536 : cfg_i.depth;
    modv  = lfo_q * $signed({1'b0, dsat});
    sum_s = 36'(modv) + 36'sd2147483648;
    sum_d = sum_s[32:0];
  end

  assign prod_d = 52'(cfg_i.half_delay) * 52'(sum_q);

  always_comb begin
    logic [24:0] rawe;
    rawe = 25'(prod_q[51:31]);
    if (rawe < 25'd256) begin
      delay_d = svd_pkg::DELAY_W'(256);
    end else if (rawe > 25'(MaxDelay)) begin
      delay_d = svd_pkg::DELAY_W'(MaxDelay);
    end else begin
      delay_d = svd_pkg::DELAY_W'(rawe);
    end
  end

  assign push_job_o.left  = left_q;
  assign push_job_o.right = right_q;
  assign push_job_o.delay = delay_d;

  always_comb begin
    state_d      = state_q;
    in_i.ready   = 1'b0;
    push_valid_o = 1'b0;
    unique case (state_q)
      svd_pkg::F_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          state_d = svd_pkg::F_IDX;
        end
      end
      svd_pkg::F_IDX:  state_d = svd_pkg::F_LFO;
      svd_pkg::F_LFO:  state_d = svd_pkg::F_MUL1;
      svd_pkg::F_MUL1: state_d = svd_pkg::F_MUL2;
      svd_pkg::F_MUL2: state_d = svd_pkg::F_PUSH;
      svd_pkg::F_PUSH: begin
        push_valid_o = 1'b1;
        if (push_ready_i) begin
          state_d = svd_pkg::F_IDLE;
        end
      end
      default: state_d = svd_pkg::F_IDLE;
    endcase
  end

endmodule

// File: rtl/svd_fifo.sv
module svd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  input  svd_pkg::job_t push_job_i,
  output logic          push_ready_o,
  output logic          pop_valid_o,
  output svd_pkg::job_t pop_job_o,
  input  logic          pop_ready_i
);

  localparam int unsigned PtrW = $clog2(svd_pkg::FIFO_DEPTH);
  localparam int unsigned CntW = $clog2(svd_pkg::FIFO_DEPTH + 1);

  svd_pkg::job_t  slot_q [svd_pkg::FIFO_DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(svd_pkg::FIFO_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_job_o    = slot_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrW'(svd_pkg::FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PtrW'(svd_pkg::FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= push_job_i;
    end
  end

endmodule

// File: rtl/svd_back.sv
module svd_back #(
  parameter int unsigned DelayDepth = svd_pkg::DELAY_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [16:0]   mix_i,
  input  logic          pop_valid_i,
  input  svd_pkg::job_t pop_job_i,
  output logic          pop_ready_o,
  svd_out_if.source     out_o
);

  localparam int unsigned AW   = $clog2(DelayDepth);
  localparam int unsigned FW   = $clog2(DelayDepth + 1);
  localparam int unsigned PosW = AW + 8;
  localparam int unsigned SW   = svd_pkg::SAMPLE_W;
  localparam longint MaxDelay  = (longint'(DelayDepth) - 1) * 256;

  svd_pkg::back_state_e state_q, state_d;
  logic [AW-1:0]   wp_q;
  logic [FW-1:0]   fill_q;
  svd_pkg::job_t   job_q;
  logic [PosW-1:0] pos_q, pos_d;
  logic [AW-1:0]   i0, i1, i1_q;
  logic            v0_q, v1_q;
  logic signed [33:0] acc_l_q, acc_r_q;
  logic signed [24:0] wet_l_q, wet_r_q;
  logic signed [41:0] dm_l_q, dm_r_q;
  logic               out_valid_q;
  logic signed [SW-1:0] out_l_q, out_r_q, sat_l, sat_r;

  logic            ram_we;
  logic [AW-1:0]   ram_raddr;
  logic [2*SW-1:0] ram_rdata;
  logic signed [SW-1:0] rd_l, rd_r;
  logic            rd_valid;
  logic [16:0]     msat;
  logic [7:0]      frac;
  logic            load_out;

  svd_ram #(
    .Width (2 * SW),
    .Depth (DelayDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i ({job_q.left, job_q.right}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Entries beyond the fill count were never written and read as zero.
  assign rd_valid = (state_q == svd_pkg::B_RD1) ? v0_q : v1_q;
  assign rd_l     = rd_valid ? $signed(ram_rdata[2*SW-1:SW]) : '0;
  assign rd_r     = rd_valid ? $signed(ram_rdata[SW-1:0]) : '0;

  assign i0   = pos_q[PosW-1:8];
  assign i1   = (i0 == AW'(DelayDepth - 1)) ? '0 : i0 + 1'b1;
  assign frac = pos_q[7:0];
  assign msat = (mix_i > 17'd65536) ? 17'd65536 : mix_i;

  always_comb begin
    logic signed [PosW+1:0] diff;
    diff = $signed({2'b0, wp_q, 8'b0}) - $signed({2'b0, job_q.delay[PosW-1:0]});
    if (diff < 0) begin
      diff = diff + (PosW+2)'(DelayDepth * 256);
    end
    pos_d = diff[PosW-1:0];
  end

  always_comb begin
    logic signed [43:0] tl, tr;
    tl = 44'(dm_l_q) + 44'(wet_l_q * $signed({1'b0, msat})) + 44'sd32768;
    tr = 44'(dm_r_q) + 44'(wet_r_q * $signed({1'b0, msat})) + 44'sd32768;
    tl = tl >>> 16;
    tr = tr >>> 16;
    if (tl > 44'sd8388607) begin
      sat_l = 24'sh7FFFFF;
    end else if (tl < -44'sd8388608) begin
      sat_l = -24'sh800000;
    end else begin
      sat_l = SW'(tl);
    end
    if (tr > 44'sd8388607) begin
      sat_r = 24'sh7FFFFF;
    end else if (tr < -44'sd8388608) begin
      sat_r = -24'sh800000;
    end else begin
      sat_r = SW'(tr);
    end
  end

  always_comb begin
    state_d     = state_q;
    pop_ready_o = 1'b0;
    ram_we      = 1'b0;
    ram_raddr   = i0;
    load_out    = 1'b0;
    unique case (state_q)
      svd_pkg::B_IDLE: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i) begin
          state_d = svd_pkg::B_WRITE;
        end
      end
      svd_pkg::B_WRITE: begin
        ram_we  = 1'b1;
        state_d = svd_pkg::B_RD0;
      end
      svd_pkg::B_RD0: begin
        ram_raddr = i0;
        state_d   = svd_pkg::B_RD1;
      end
      svd_pkg::B_RD1: begin
        ram_raddr = i1_q;
        state_d   = svd_pkg::B_INTERP;
      end
      svd_pkg::B_INTERP: state_d = svd_pkg::B_MIX1;
      svd_pkg::B_MIX1:   state_d = svd_pkg::B_MIX2;
      svd_pkg::B_MIX2: begin
        if (!out_valid_q || out_o.ready) begin
          load_out = 1'b1;
          state_d  = svd_pkg::B_IDLE;
        end
      end
      default: state_d = svd_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= svd_pkg::B_IDLE;
      wp_q        <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ram_we && fill_q != FW'(DelayDepth)) begin
        fill_q <= fill_q + 1'b1;
      end
      if (load_out) begin
        wp_q        <= (wp_q == AW'(DelayDepth - 1)) ? '0 : wp_q + 1'b1;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      svd_pkg::B_IDLE: begin
        job_q <= pop_job_i;
      end
      svd_pkg::B_WRITE: begin
        pos_q <= pos_d;
      end
      svd_pkg::B_RD0: begin
        v0_q <= (FW'(i0) < fill_q);
        v1_q <= (FW'(i1) < fill_q);
        i1_q <= i1;
      end
      svd_pkg::B_RD1: begin
        acc_l_q <= rd_l * $signed({1'b0, 9'(9'd256 - {1'b0, frac})});
        acc_r_q <= rd_r * $signed({1'b0, 9'(9'd256 - {1'b0, frac})});
      end
      svd_pkg::B_INTERP: begin
        wet_l_q <= 25'((35'(acc_l_q) + 35'(rd_l * $signed({2'b0, frac})) + 35'sd128) >>> 8);
        wet_r_q <= 25'((35'(acc_r_q) + 35'(rd_r * $signed({2'b0, frac})) + 35'sd128) >>> 8);
      end
      svd_pkg::B_MIX1: begin
        dm_l_q <= job_q.left * $signed({1'b0, 17'(17'd65536 - msat)});
        dm_r_q <= job_q.right * $signed({1'b0, 17'(17'd65536 - msat)});
      end
      svd_pkg::B_MIX2: begin
        if (load_out) begin
          out_l_q <= sat_l;
          out_r_q <= sat_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.left_out  = out_l_q;
  assign out_o.right_out = out_r_q;

`ifndef ASSERT_OFF
  a_wp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(wp_q) < DelayDepth)
    else $error("write position out of range");

  a_fill_tracks_wp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == svd_pkg::B_IDLE && 32'(fill_q) < DelayDepth) |-> (32'(wp_q) == 32'(fill_q)))
    else $error("fill count and write position disagree");

  a_delay_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == svd_pkg::B_WRITE) |->
      (job_q.delay >= svd_pkg::DELAY_W'(256) && 64'(job_q.delay) <= 64'(MaxDelay)))
    else $error("delay outside clamp range");
`endif

endmodule

// File: rtl/stereo_vibrato_delay_top.sv
// Stereo vibrato: each input beat carries one left/right Q1.23 sample pair and
// yields exactly one output beat with the mixed pair. A front section advances
// the LFO phase, evaluates the selected waveform and forms the modulated delay;
// a two-entry queue decouples it from a back section that writes both samples
// into one shared delay RAM, reads two interpolation taps through its single
// read port and mixes dry with wet. Each section works on one beat at a time;
// the back section is the slower and sets the sustained rate. The output is
// registered, so a new input is taken while a result waits. Delay RAM entries
// not yet written read as zero, so no clearing pass follows reset. Registers
// are to be written through the config channel while the block is idle; the
// block does not enforce this. Unknown register indices are ignored.
module stereo_vibrato_delay_top #(
  parameter int unsigned DelayDepth  = svd_pkg::DELAY_DEPTH_DEF,
  parameter int unsigned SineEntries = svd_pkg::SINE_ENTRIES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  svd_cfg_if.sink    cfg_i,
  svd_in_if.sink     in_i,
  svd_out_if.source  out_o
);

  svd_pkg::cfg_t cfg_q;
  logic          push_valid, push_ready, pop_valid, pop_ready;
  svd_pkg::job_t push_job, pop_job;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.phase_step <= 32'd4473924;
      cfg_q.half_delay <= 19'd122880;
      cfg_q.depth      <= '0;
      cfg_q.wave       <= svd_pkg::WAVE_SINE;
      cfg_q.mix        <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        svd_pkg::CFG_PHASE_STEP: cfg_q.phase_step <= cfg_i.data;
        svd_pkg::CFG_HALF_DELAY: cfg_q.half_delay <= cfg_i.data[18:0];
        svd_pkg::CFG_DEPTH:      cfg_q.depth      <= cfg_i.data[16:0];
        svd_pkg::CFG_WAVE:       cfg_q.wave       <= svd_pkg::wave_e'(cfg_i.data[1:0]);
        svd_pkg::CFG_MIX:        cfg_q.mix        <= cfg_i.data[16:0];
        default: begin
        end
      endcase
    end
  end

  svd_front #(
    .DelayDepth  (DelayDepth),
    .SineEntries (SineEntries)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_job_o   (push_job),
    .push_ready_i (push_ready)
  );

  svd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_job_i   (push_job),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_job_o    (pop_job),
    .pop_ready_i  (pop_ready)
  );

  svd_back #(
    .DelayDepth (DelayDepth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mix_i       (cfg_q.mix),
    .pop_valid_i (pop_valid),
    .pop_job_i   (pop_job),
    .pop_ready_o (pop_ready),
    .out_o       (out_o)
  );

endmodule
